@@ rtl/tts_pkg.sv @@
// ============================================================================
// tts_pkg
// Shared types and constants for the tick task scheduler: beat payloads,
// action codes and the command/status bundles between controller and datapath.
// ============================================================================
package tts_pkg;

   localparam int SLOTS     = 4;
   localparam int SLOT_BITS = 2;
   localparam int TIME_BITS = 32;
   localparam int TAG_BITS  = 8;
   localparam int PEND_BITS = 8;

   localparam logic [PEND_BITS-1:0] PEND_MAX = 8'hFF;

   localparam logic [1:0] ACT_TICK     = 2'd0;
   localparam logic [1:0] ACT_ADD      = 2'd1;
   localparam logic [1:0] ACT_DELETE   = 2'd2;
   localparam logic [1:0] ACT_DISPATCH = 2'd3;

   typedef struct packed {
      logic [1:0]           action;
      logic [TAG_BITS-1:0]  task_tag;
      logic [TIME_BITS-1:0] start_delay;
      logic [TIME_BITS-1:0] repeat_period;
      logic [SLOT_BITS-1:0] target_slot;
   } req_type;

   typedef struct packed {
      logic [SLOT_BITS-1:0] result_slot;
      logic [TAG_BITS-1:0]  result_tag;
      logic                 result_valid;
      logic                 result_last;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic                 tick;
      logic                 add;
      logic                 del;
      logic                 disp;
      logic [SLOT_BITS-1:0] slot;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic                 free_ok;
      logic [SLOT_BITS-1:0] free_slot;
      logic [SLOTS-1:0]     due_mask;
      logic [TAG_BITS-1:0]  sel_tag;
   } stat_type;

endpackage

@@ rtl/tts_datapath.sv @@
// ============================================================================
// tts_datapath
// Slot table: used bits, tags, delay counters, periods and pending-run counts.
// ============================================================================
module tts_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  tts_pkg::cmd_type              cmd,
   input  logic [tts_pkg::TAG_BITS-1:0]  add_tag,
   input  logic [tts_pkg::TIME_BITS-1:0] add_delay,
   input  logic [tts_pkg::TIME_BITS-1:0] add_period,
   output tts_pkg::stat_type             stat
);

   logic [tts_pkg::SLOTS-1:0]     used_ff, used_in;
   logic [tts_pkg::TAG_BITS-1:0]  tag_ff    [tts_pkg::SLOTS];
   logic [tts_pkg::TAG_BITS-1:0]  tag_in    [tts_pkg::SLOTS];
   logic [tts_pkg::TIME_BITS-1:0] delay_ff  [tts_pkg::SLOTS];
   logic [tts_pkg::TIME_BITS-1:0] delay_in  [tts_pkg::SLOTS];
   logic [tts_pkg::TIME_BITS-1:0] period_ff [tts_pkg::SLOTS];
   logic [tts_pkg::TIME_BITS-1:0] period_in [tts_pkg::SLOTS];
   logic [tts_pkg::PEND_BITS-1:0] pend_ff   [tts_pkg::SLOTS];
   logic [tts_pkg::PEND_BITS-1:0] pend_in   [tts_pkg::SLOTS];

   // per-slot next state; commands are mutually exclusive
   always_comb begin
      for (int i = 0; i < tts_pkg::SLOTS; i++) begin
         logic hit;
         hit          = (cmd.slot == tts_pkg::SLOT_BITS'(i));
         used_in[i]   = used_ff[i];
         tag_in[i]    = tag_ff[i];
         delay_in[i]  = delay_ff[i];
         period_in[i] = period_ff[i];
         pend_in[i]   = pend_ff[i];
         if (cmd.tick && used_ff[i]) begin
            if (delay_ff[i] == '0) begin
               if (pend_ff[i] != tts_pkg::PEND_MAX)
                  pend_in[i] = pend_ff[i] + 1'b1;
               if (period_ff[i] != '0)
                  delay_in[i] = period_ff[i] - 1'b1;
            end else begin
               delay_in[i] = delay_ff[i] - 1'b1;
            end
         end else if (cmd.add && hit) begin
            used_in[i]   = 1'b1;
            tag_in[i]    = add_tag;
            delay_in[i]  = add_delay;
            period_in[i] = add_period;
            pend_in[i]   = '0;
         end else if (cmd.del && hit) begin
            used_in[i]   = 1'b0;
            pend_in[i]   = '0;
         end else if (cmd.disp && hit) begin
            pend_in[i] = pend_ff[i] - 1'b1;
            // one-shot task leaves the table once run
            if (period_ff[i] == '0)
               used_in[i] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else begin
         used_ff <= used_in;
      end
      for (int i = 0; i < tts_pkg::SLOTS; i++) begin
         tag_ff[i]    <= tag_in[i];
         delay_ff[i]  <= delay_in[i];
         period_ff[i] <= period_in[i];
         pend_ff[i]   <= pend_in[i];
      end
   end

   // status: lowest free slot, due slots, tag of addressed slot
   always_comb begin
      stat.free_ok   = ~&used_ff;
      stat.free_slot = '0;
      for (int i = tts_pkg::SLOTS - 1; i >= 0; i--) begin
         if (!used_ff[i])
            stat.free_slot = tts_pkg::SLOT_BITS'(i);
      end
      for (int i = 0; i < tts_pkg::SLOTS; i++)
         stat.due_mask[i] = used_ff[i] && (pend_ff[i] != '0);
      stat.sel_tag = tag_ff[cmd.slot];
   end

endmodule

@@ rtl/tts_ctrl.sv @@
// ============================================================================
// tts_ctrl
// Action decode, dispatch scan sequencer and result register.
// ============================================================================
module tts_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic [1:0]                   req_action,
   input  logic [tts_pkg::TAG_BITS-1:0] req_tag,
   input  logic [tts_pkg::SLOT_BITS-1:0] req_target,
   output logic                         req_stall,
   output logic                         rsp_valid,
   output tts_pkg::rsp_type             rsp_data,
   input  logic                         rsp_stall,
   output tts_pkg::cmd_type             cmd,
   input  tts_pkg::stat_type            stat
);

   typedef enum logic {IDLE, SCAN} state_type;

   state_type                 state_ff, state_in;
   logic [tts_pkg::SLOTS-1:0] left_ff, left_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   tts_pkg::rsp_type          rsp_data_ff, rsp_data_in;

   logic                          out_free;
   logic                          accept;
   logic [tts_pkg::SLOT_BITS-1:0] pick;
   logic [tts_pkg::SLOTS-1:0]     pick_oh;
   logic [tts_pkg::SLOTS-1:0]     left_rest;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != IDLE) || !out_free;
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // lowest remaining due slot
   always_comb begin
      pick = '0;
      for (int i = tts_pkg::SLOTS - 1; i >= 0; i--) begin
         if (left_ff[i])
            pick = tts_pkg::SLOT_BITS'(i);
      end
      pick_oh   = tts_pkg::SLOTS'(1) << pick;
      left_rest = left_ff & ~pick_oh;
   end

   always_comb begin
      state_in     = state_ff;
      left_in      = left_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      cmd          = '0;
      unique case (state_ff)
         IDLE: begin
            if (accept) begin
               unique case (req_action)
                  tts_pkg::ACT_TICK: begin
                     cmd.tick = 1'b1;
                  end
                  tts_pkg::ACT_ADD: begin
                     cmd.add      = stat.free_ok;
                     cmd.slot     = stat.free_slot;
                     rsp_valid_in = 1'b1;
                     rsp_data_in.result_slot  = stat.free_ok ? stat.free_slot : '0;
                     rsp_data_in.result_tag   = stat.free_ok ? req_tag : '0;
                     rsp_data_in.result_valid = stat.free_ok;
                     rsp_data_in.result_last  = 1'b1;
                  end
                  tts_pkg::ACT_DELETE: begin
                     cmd.del  = 1'b1;
                     cmd.slot = req_target;
                  end
                  tts_pkg::ACT_DISPATCH: begin
                     if (stat.due_mask == '0) begin
                        rsp_valid_in = 1'b1;
                        rsp_data_in  = '{result_slot: '0, result_tag: '0,
                                         result_valid: 1'b0, result_last: 1'b1};
                     end else begin
                        left_in  = stat.due_mask;
                        state_in = SCAN;
                     end
                  end
                  default: ;
               endcase
            end
         end
         SCAN: begin
            if (out_free) begin
               cmd.disp     = 1'b1;
               cmd.slot     = pick;
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{result_slot: pick, result_tag: stat.sel_tag,
                                result_valid: 1'b1, result_last: (left_rest == '0)};
               left_in      = left_rest;
               if (left_rest == '0)
                  state_in = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         left_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         left_ff      <= left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

endmodule

@@ rtl/tick_task_scheduler.sv @@
// ============================================================================
// tick_task_scheduler
// Cooperative time-triggered scheduler over a four-slot task table.
//
// Usage:
//  - req_* carries one action per beat: tick, add task, delete slot, or
//    dispatch. A beat is taken when req_valid is high and req_stall is low.
//  - rsp_* returns results. Tick and delete give none; add gives one beat
//    (slot taken, or result_valid low when the table is full); dispatch gives
//    one beat per due slot in slot order, or a single "none due" beat.
//    result_last marks the final beat of each action.
//  - The result of add or an empty dispatch is registered when the beat is
//    accepted. A dispatch with due slots first moves to the scan state, then
//    emits one beat per cycle while the output register is free to take it.
//  - The table update for a tick covers all slots in parallel.
//  - Reset (synchronous, active high) frees every slot and clears the
//    output valid flag; slot payloads are rewritten by the next add.
//  - When rsp_stall holds the output register full, req_stall rises and the
//    dispatch scan pauses; no beat is lost or repeated.
// ============================================================================
module tick_task_scheduler (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  tts_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output tts_pkg::rsp_type rsp_data
);

   tts_pkg::cmd_type  cmd;
   tts_pkg::stat_type stat;

   // sequencer and result register
   tts_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_data.action),
      .req_tag    (req_data.task_tag),
      .req_target (req_data.target_slot),
      .req_stall  (req_stall),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data),
      .rsp_stall  (rsp_stall),
      .cmd        (cmd),
      .stat       (stat)
   );

   // slot table
   tts_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .add_tag    (req_data.task_tag),
      .add_delay  (req_data.start_delay),
      .add_period (req_data.repeat_period),
      .stat       (stat)
   );

endmodule
